>>> sv/waveform_oscillator_nco_macros.svh
// Assertion macros for the checker file of the oscillator.
// Both expect signals named clk and rst in the scope where they are used.
`ifndef WAVEFORM_OSCILLATOR_NCO_MACROS_SVH
`define WAVEFORM_OSCILLATOR_NCO_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NCO_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NCO_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/nco_pkg.sv
`timescale 1ns / 1ps

package nco_pkg;

  // Phase bits that address the sine curve; the rest of the phase is dropped.
  localparam int SINE_TABLE_BITS = 10;
  localparam logic [31:0] SINE_MASK = ~((32'd1 << (32 - SINE_TABLE_BITS)) - 32'd1);

  localparam logic [30:0] Q30_ONE = 31'd1073741824;

  // Odd polynomial for sin(pi/2 * x), Q30 coefficients.
  localparam logic [30:0] SC1 = 31'd1686629713;
  localparam logic [30:0] SC3 = 31'd693598668;
  localparam logic [30:0] SC5 = 31'd85569306;
  localparam logic [30:0] SC7 = 31'd5026995;
  localparam logic [30:0] SC9 = 31'd172272;

  // 0.1 in Q15, used for the brownian walk step.
  localparam logic [31:0] WALK_SCALE = 32'd3277;

  // The serial multiplier retires one multiplier bit per cycle.
  localparam int MUL_BITS = 32;
  localparam logic [4:0] MUL_LAST = 5'(MUL_BITS - 1);

  localparam logic [15:0] AMPLITUDE_RESET = 16'd4096;

  typedef enum logic [2:0] {
    WAVE_SINE     = 3'd0,
    WAVE_SQUARE   = 3'd1,
    WAVE_TRIANGLE = 3'd2,
    WAVE_SAW      = 3'd3,
    WAVE_WHITE    = 3'd4,
    WAVE_PINK     = 3'd5,
    WAVE_BROWN    = 3'd6
  } wave_t;

  typedef enum logic [1:0] {
    CFG_WAVEFORM  = 2'd0,
    CFG_AMPLITUDE = 2'd1,
    CFG_BASE_STEP = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_MUL  = 3'b010,
    S_POST = 3'b100
  } state_t;

  // Which product the multiplier is working on.
  typedef enum logic [10:0] {
    OP_X2   = 11'b00000000001,
    OP_C7   = 11'b00000000010,
    OP_C5   = 11'b00000000100,
    OP_C3   = 11'b00000001000,
    OP_C1   = 11'b00000010000,
    OP_XP   = 11'b00000100000,
    OP_WALK = 11'b00001000000,
    OP_GAIN = 11'b00010000000,
    OP_MAG  = 11'b00100000000,
    OP_S1   = 11'b01000000000,
    OP_STEP = 11'b10000000000
  } op_t;

endpackage

>>> sv/waveform_oscillator_nco.sv
`timescale 1ns / 1ps

// Oscillator that turns each accepted audio tick into one Q1.15 sample and then
// advances its 32-bit phase by base_step*freq_env*(1+fm_in). All products go
// through one shift-and-add multiplier that retires one multiplier bit per cycle,
// so each product runs through its bit steps in S_MUL and is then used in S_POST.
// Brownian adds the walk product to the chain used for square, triangle, sawtooth,
// white and pink, and sine needs six more products for the ninth-order polynomial.
// The input stalls while an item is in work; the finished sample sits in an output
// register, and the next tick may be taken while it waits. If that register is
// still full at the end of the next item, the block holds until the sample is taken.
// Configuration writes are always ready.
module waveform_oscillator_nco import nco_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic        [15:0] amp_env,
  input  logic        [15:0] freq_env,
  input  logic signed [15:0] fm_in,
  input  logic               noise_sign,
  input  logic        [14:0] noise_mag,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] sample,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic        [1:0]  cfg_index,
  input  logic        [31:0] cfg_data
);

  logic        [2:0]  waveform;
  logic        [15:0] amplitude;
  logic        [31:0] base_step;
  logic        [31:0] phase_acc;
  logic signed [16:0] brown_level;

  state_t state;
  op_t    op;

  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [31:0] mul_acc;
  logic [4:0]  mul_cnt;

  logic        [30:0] x2;
  logic signed [17:0] w_val;
  logic        [15:0] y_val;
  logic        [15:0] y_hold;
  logic        [15:0] amp_env_r;
  logic        [15:0] freq_env_r;
  logic        [15:0] fm_r;
  logic               nsign_r;

  logic               in_accept;
  logic               cfg_write;
  logic               out_free;
  logic               out_load;
  logic        [32:0] mul_sum;
  logic        [63:0] prod;
  logic        [31:0] sine_q;
  logic        [30:0] sine_f;
  logic        [30:0] sine_x;
  logic        [30:0] poly_t;
  logic        [30:0] poly_coef;
  logic        [30:0] poly_p;
  logic        [31:0] qs_round;
  logic        [16:0] sine_v;
  logic signed [17:0] w_sine;
  logic signed [17:0] w_direct;
  logic        [27:0] walk_round;
  logic        [12:0] walk;
  logic signed [17:0] walk_s;
  logic signed [17:0] brown_ext;
  logic signed [17:0] brown_sum;
  logic signed [17:0] brown_new;
  logic        [17:0] w_neg;
  logic        [16:0] w_abs;
  logic        [20:0] y_mag;
  logic        [15:0] y_neg;
  logic        [15:0] y_sat;
  logic        [31:0] step_lo;

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign out_free  = !out_valid || !out_stall;
  assign out_load  = (state == S_POST) && (op == OP_STEP) && out_free;
  assign sample    = y_hold;

  // The multiplier bits leave mul_b at the bottom while product bits enter at the top.
  assign mul_sum = {1'b0, mul_acc} + (mul_b[0] ? {1'b0, mul_a} : 33'd0);
  assign prod    = {mul_acc, mul_b};

  // Quarter-wave fold of the truncated phase.
  assign sine_q = phase_acc & SINE_MASK;
  assign sine_f = {1'b0, sine_q[29:0]};
  assign sine_x = phase_acc[30] ? (Q30_ONE - sine_f) : sine_f;

  assign poly_t = prod[60:30];

  always_comb begin
    case (op)
      OP_C7:   poly_coef = SC7;
      OP_C5:   poly_coef = SC5;
      OP_C3:   poly_coef = SC3;
      default: poly_coef = SC1;
    endcase
  end

  assign poly_p   = poly_coef - poly_t;
  assign qs_round = {1'b0, prod[60:30]} + 32'd16384;
  assign sine_v   = qs_round[31:15];
  assign w_sine   = phase_acc[31] ? -$signed({1'b0, sine_v}) : $signed({1'b0, sine_v});

  always_comb begin
    case (waveform)
      WAVE_SQUARE:   w_direct = phase_acc[31] ? 18'sd32768 : -18'sd32768;
      WAVE_TRIANGLE: w_direct = phase_acc[31]
                                ? 18'sd98304 - $signed({1'b0, phase_acc[31:15]})
                                : $signed({1'b0, phase_acc[31:15]}) - 18'sd32768;
      WAVE_SAW:      w_direct = 18'sd32768 - $signed({2'b0, phase_acc[31:16]});
      WAVE_WHITE:    w_direct = noise_sign ? -$signed({3'b0, noise_mag})
                                           : $signed({3'b0, noise_mag});
      default:       w_direct = '0;
    endcase
  end

  // The walk bounces back when a step would leave the range of plus or minus one.
  assign walk_round = prod[27:0] + 28'd16384;
  assign walk       = walk_round[27:15];
  assign walk_s     = nsign_r ? -$signed({5'b0, walk}) : $signed({5'b0, walk});
  assign brown_ext  = {brown_level[16], brown_level};
  assign brown_sum  = brown_ext + walk_s;
  assign brown_new  = (brown_sum > 18'sd32768 || brown_sum < -18'sd32768)
                      ? brown_ext - walk_s : brown_sum;

  assign w_neg = -w_val;
  assign w_abs = w_val[17] ? w_neg[16:0] : w_val[16:0];

  // Round half away from zero on the magnitude, then saturate with the sign.
  assign y_mag = prod[48:28] + {20'd0, prod[27]};
  assign y_neg = -y_mag[15:0];

  always_comb begin
    if (!w_val[17]) begin
      y_sat = (y_mag > 21'd32767) ? 16'h7FFF : y_mag[15:0];
    end else begin
      y_sat = (y_mag >= 21'd32768) ? 16'h8000 : y_neg;
    end
  end

  assign step_lo = prod[46:15];

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      op          <= OP_GAIN;
      out_valid   <= 1'b0;
      waveform    <= WAVE_SINE;
      amplitude   <= AMPLITUDE_RESET;
      base_step   <= '0;
      phase_acc   <= '0;
      brown_level <= '0;
      mul_cnt     <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_WAVEFORM:  waveform  <= cfg_data[2:0];
          CFG_AMPLITUDE: amplitude <= cfg_data[15:0];
          CFG_BASE_STEP: base_step <= cfg_data;
          default: ;
        endcase
      end

      // The waiting sample is replaced only when it leaves in this same cycle or is gone.
      if (out_load) begin
        out_valid <= 1'b1;
        y_hold    <= y_val;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_accept) begin
            amp_env_r  <= amp_env;
            freq_env_r <= freq_env;
            fm_r       <= fm_in;
            nsign_r    <= noise_sign;
            mul_acc    <= '0;
            state      <= S_MUL;
            case (waveform)
              WAVE_SQUARE, WAVE_TRIANGLE, WAVE_SAW, WAVE_WHITE, WAVE_PINK: begin
                w_val <= w_direct;
                mul_a <= {16'd0, amplitude};
                mul_b <= {16'd0, amp_env};
                op    <= OP_GAIN;
              end
              WAVE_BROWN: begin
                mul_a <= {17'd0, noise_mag};
                mul_b <= WALK_SCALE;
                op    <= OP_WALK;
              end
              default: begin
                mul_a <= {1'b0, sine_x};
                mul_b <= {1'b0, sine_x};
                op    <= OP_X2;
              end
            endcase
          end
        end

        S_MUL: begin
          mul_acc <= mul_sum[32:1];
          mul_b   <= {mul_sum[0], mul_b[31:1]};
          mul_cnt <= mul_cnt + 5'd1;
          if (mul_cnt == MUL_LAST) begin
            state <= S_POST;
          end
        end

        S_POST: begin
          // The final product stays in place until the output register is free.
          if (op != OP_STEP) begin
            mul_acc <= '0;
            state   <= S_MUL;
          end
          case (op)
            OP_X2: begin
              x2    <= poly_t;
              mul_a <= {1'b0, poly_t};
              mul_b <= {1'b0, SC9};
              op    <= OP_C7;
            end
            OP_C7: begin
              mul_a <= {1'b0, x2};
              mul_b <= {1'b0, poly_p};
              op    <= OP_C5;
            end
            OP_C5: begin
              mul_a <= {1'b0, x2};
              mul_b <= {1'b0, poly_p};
              op    <= OP_C3;
            end
            OP_C3: begin
              mul_a <= {1'b0, x2};
              mul_b <= {1'b0, poly_p};
              op    <= OP_C1;
            end
            OP_C1: begin
              mul_a <= {1'b0, sine_x};
              mul_b <= {1'b0, poly_p};
              op    <= OP_XP;
            end
            OP_XP: begin
              w_val <= w_sine;
              mul_a <= {16'd0, amplitude};
              mul_b <= {16'd0, amp_env_r};
              op    <= OP_GAIN;
            end
            OP_WALK: begin
              brown_level <= brown_new[16:0];
              w_val       <= brown_new;
              mul_a       <= {16'd0, amplitude};
              mul_b       <= {16'd0, amp_env_r};
              op          <= OP_GAIN;
            end
            OP_GAIN: begin
              mul_a <= prod[31:0];
              mul_b <= {15'd0, w_abs};
              op    <= OP_MAG;
            end
            OP_MAG: begin
              y_val <= y_sat;
              mul_a <= base_step;
              mul_b <= {16'd0, freq_env_r};
              op    <= OP_S1;
            end
            OP_S1: begin
              // 32768 + fm_in is the offset-binary form of fm_in.
              mul_a <= prod[47:16];
              mul_b <= {16'd0, ~fm_r[15], fm_r[14:0]};
              op    <= OP_STEP;
            end
            OP_STEP: begin
              if (out_free) begin
                phase_acc <= phase_acc + step_lo;
                state     <= S_IDLE;
              end
            end
            default: state <= S_IDLE;
          endcase
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> sv/nco_checker.sv
`timescale 1ns / 1ps

`include "waveform_oscillator_nco_macros.svh"

module nco_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] sample
);

  // An accepted tick keeps the block busy for at least the next cycle.
  `NCO_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "no stall after input transaction")

  // Several serial products lie between a tick and its sample.
  `NCO_ASSERT_NEXT(a_no_instant_result, in_valid && !in_stall, !$rose(out_valid), "sample appeared right after input transaction")

  // A new sample is only produced while an item is in work.
  `NCO_ASSERT_SAME(a_result_from_work, $rose(out_valid), $past(in_stall), "sample appeared while idle")

  `NCO_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(sample), "stalled sample changed")

  `NCO_ASSERT_SAME(a_out_drop, $fell(out_valid), $past(!out_stall), "sample dropped without a transaction")

endmodule

bind waveform_oscillator_nco nco_checker u_nco_checker (.*);
